// ----- src/sitoa_pkg.sv -----
`default_nettype none
package sitoa_pkg;

   localparam int CHAR_WIDTH  = 6;
   localparam int DIGIT_WIDTH = 4;
   localparam int DABBLE_BITS = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_ADD   = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LOCATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic locate;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic idx_zero;
   } status_type;

endpackage
`default_nettype wire

// ----- src/sitoa_ctrl.sv -----
`default_nettype none
module sitoa_ctrl
   import sitoa_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (status.conv_done) state_in = ST_LOCATE;
         end
         ST_LOCATE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.idx_zero) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy           = 1'b1;
      cmd.load       = 1'b0;
      cmd.convert    = 1'b0;
      cmd.locate     = 1'b0;
      cmd.emit_digit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
         end
         ST_LOCATE: begin
            cmd.locate = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit_digit = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- src/sitoa_datapath.sv -----
`default_nettype none
module sitoa_datapath
   import sitoa_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire signed [VALUE_WIDTH-1:0] req_value,
   input  cmd_type                      cmd,
   output status_type                   status,
   output logic                         rsp_valid,
   output logic [CHAR_WIDTH-1:0]        rsp_character,
   output logic                         rsp_last
);

   localparam int STEPS       = (VALUE_WIDTH + DABBLE_BITS - 1) / DABBLE_BITS;
   localparam int PAD_WIDTH   = STEPS * DABBLE_BITS;
   localparam int NUM_DIGITS  = (VALUE_WIDTH * 3) / 10 + 1;
   localparam int BCD_WIDTH   = NUM_DIGITS * DIGIT_WIDTH;
   localparam int STEP_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_W       = $clog2(NUM_DIGITS);

   logic [VALUE_WIDTH-1:0] value_u;
   logic [VALUE_WIDTH-1:0] mag;

   logic [PAD_WIDTH-1:0]   bin_ff,  bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff,  bcd_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [IDX_W-1:0]       idx_ff,  idx_in;
   logic                   neg_ff,  neg_in;

   logic                   rsp_valid_ff,     rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_character_ff, rsp_character_in;
   logic                   rsp_last_ff,      rsp_last_in;

   logic [BCD_WIDTH-1:0]   bcd_step;
   logic [PAD_WIDTH-1:0]   bin_step;
   logic [IDX_W-1:0]       top_idx;
   logic [DIGIT_WIDTH-1:0] cur_digit;

   assign value_u = req_value;
   assign mag     = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;

   always_comb begin
      logic [BCD_WIDTH-1:0] b;
      logic [PAD_WIDTH-1:0] s;
      b = bcd_ff;
      s = bin_ff;
      for (int k = 0; k < DABBLE_BITS; k++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (b[d*DIGIT_WIDTH +: DIGIT_WIDTH] >= DABBLE_LIMIT) begin
               b[d*DIGIT_WIDTH +: DIGIT_WIDTH] = b[d*DIGIT_WIDTH +: DIGIT_WIDTH] + DABBLE_ADD;
            end
         end
         b = {b[BCD_WIDTH-2:0], s[PAD_WIDTH-1]};
         s = {s[PAD_WIDTH-2:0], 1'b0};
      end
      bcd_step = b;
      bin_step = s;
   end

   always_comb begin
      top_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_WIDTH +: DIGIT_WIDTH] != '0) top_idx = IDX_W'(d);
      end
   end

   assign cur_digit = bcd_ff[idx_ff*DIGIT_WIDTH +: DIGIT_WIDTH];

   assign status.conv_done = (step_ff == STEP_W'(STEPS - 1));
   assign status.idx_zero  = (idx_ff == '0);

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      neg_in  = neg_ff;
      if (cmd.load) begin
         bin_in  = PAD_WIDTH'(mag);
         bcd_in  = '0;
         step_in = '0;
         neg_in  = value_u[VALUE_WIDTH-1];
      end else if (cmd.convert) begin
         bin_in  = bin_step;
         bcd_in  = bcd_step;
         step_in = step_ff + STEP_W'(1);
      end else if (cmd.locate) begin
         idx_in = top_idx;
      end else if (cmd.emit_digit) begin
         idx_in = idx_ff - IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in     = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      if (cmd.locate) begin
         rsp_valid_in     = neg_ff;
         rsp_character_in = CHAR_MINUS;
         rsp_last_in      = 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = CHAR_ZERO + {2'b00, cur_digit};
         rsp_last_in      = status.idx_zero;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff           <= bin_in;
      bcd_ff           <= bcd_in;
      step_ff          <= step_in;
      idx_ff           <= idx_in;
      neg_ff           <= neg_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
`default_nettype wire

// ----- src/signed_int_to_decimal_ascii.sv -----
// Flow: the accepting edge loads the value; the controller then runs the binary-to-BCD shifter
//   (ST_CONVERT), locates the top digit (ST_LOCATE, which registers the minus sign for a negative
//   value) and emits the digits from ST_EMIT. A new value is taken only once busy drops in idle;
//   the 4-bit-per-cycle binary-to-BCD shifter runs first, then one character per cycle follows.
// Characters leave one per cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous, active high) returns the controller to idle and drops any pending strobe.
`default_nettype none
module signed_int_to_decimal_ascii
   import sitoa_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire signed [VALUE_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   output logic [CHAR_WIDTH-1:0]        rsp_character,
   output logic                         rsp_last
);

   cmd_type    cmd;
   status_type status;

   sitoa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   sitoa_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

// ----- verif/signed_int_to_decimal_ascii_tb.sv -----
`default_nettype none
module signed_int_to_decimal_ascii_tb;
   import sitoa_pkg::*;

   localparam int DIRECTED_ROWS = 18;
   localparam int RANDOM_ITEMS  = 142;
   localparam int DRAIN_CYCLES  = 16;
   localparam int STALL_LIMIT   = 1000;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } text_char_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic signed [31:0]    req_value = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [CHAR_WIDTH-1:0] rsp_character;
   logic                  rsp_last;

   text_char_type text_expected[$];
   int            errors       = 0;
   int            value_count  = 0;
   int            neg_count    = 0;
   int            char_count   = 0;
   int            stall_cycles = 0;
   bit            pace_enabled = 1'b1;

   logic signed [31:0] dir_value [DIRECTED_ROWS] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, -32'sd100,
      32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
      32'sd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
      32'sd123456789, -32'sd8
   };
   string dir_text [DIRECTED_ROWS] = '{
      "0", "1", "-1", "9", "10", "-10", "", "",
      "2147483647", "-2147483648", "-2147483647", "1000000000",
      "", "", "", "",
      "", ""
   };

   signed_int_to_decimal_ascii #(.VALUE_WIDTH(32)) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #2 clock = ~clock;

   task automatic queue_decimal_text(input logic signed [31:0] v);
      logic [31:0] magnitude;
      logic [3:0]  digits [10];
      int          n;
      magnitude = v[31] ? ~v + 32'd1 : v;
      n = 0;
      do begin
         digits[n] = 4'(magnitude % 32'd10);
         magnitude = magnitude / 32'd10;
         n++;
      end while (magnitude != 0);
      if (v[31])
         text_expected.push_back(text_char_type'{CHAR_MINUS, 1'b0});
      for (int i = n - 1; i >= 0; i--)
         text_expected.push_back(text_char_type'{CHAR_ZERO + CHAR_WIDTH'(digits[i]), i == 0});
   endtask

   task automatic queue_typed_text(input string text);
      for (int i = 0; i < text.len(); i++)
         text_expected.push_back(text_char_type'{CHAR_WIDTH'(text[i]), i == text.len() - 1});
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      logic [31:0] p;
      bit          neg_ok;
      neg_ok = 1'b1;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            v = $urandom;
            neg_ok = 1'b0;
         end
         4, 5: v = $urandom_range(199);
         6, 7: begin
            p = 32'd1;
            repeat ($urandom_range(9)) p = p * 32'd10;
            v = p + 32'($urandom_range(2)) - 32'd1;
         end
         8: begin
            v = $urandom_range(1) ? 32'h7fff_ffff - 32'($urandom_range(15))
                                  : 32'h8000_0000 + 32'($urandom_range(15));
            neg_ok = 1'b0;
         end
         default: v = $urandom >> $urandom_range(31);
      endcase
      if (neg_ok && $urandom_range(1) == 1)
         v = ~v + 32'd1;
      return v;
   endfunction

   // hold start until the block takes the transaction, then queue its text
   task automatic convert_value(input logic signed [31:0] v, input string text);
      while (pace_enabled && $urandom_range(99) < 8) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_value <= v;
      start     <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (text.len() == 0)
         queue_decimal_text(v);
      else
         queue_typed_text(text);
      value_count++;
      if (v[31])
         neg_count++;
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid) begin
         if (text_expected.size() == 0) begin
            $error("unexpected transaction: character %0d last %0b", rsp_character, rsp_last);
            errors++;
         end else begin
            want = text_expected.pop_front();
            char_count++;
            if (rsp_character !== want.character) begin
               $error("character: expected %0d, actual %0d", want.character, rsp_character);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < DIRECTED_ROWS; r++)
         convert_value(dir_value[r], dir_text[r]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pace_enabled = (n < 50 || n >= 110);
         convert_value(random_value(), "");
      end
      start <= 1'b0;
      while (text_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("converted %0d values (%0d negative), %0d characters checked", value_count,
               neg_count, char_count);
      $display("extremes, zero, power-of-ten edges and random magnitudes of every length");
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire

// ----- signed_int_to_decimal_ascii.f -----
src/sitoa_pkg.sv
src/sitoa_ctrl.sv
src/sitoa_datapath.sv
src/signed_int_to_decimal_ascii.sv
verif/signed_int_to_decimal_ascii_tb.sv
